// File: hdl/srgb_cr_pkg.sv
package srgb_cr_pkg;

    // Field and format widths.
    localparam int CHANNEL_BITS        = 8;
    localparam int RATIO_FRACTION_BITS = 11;
    localparam int RATIO_W             = RATIO_FRACTION_BITS + 5;
    localparam int LEVELS              = 1 << CHANNEL_BITS;
    localparam int Q_BITS              = 30;
    localparam int LIN_W               = Q_BITS + 1;
    localparam int LUM_W               = Q_BITS + 14;
    localparam int DIV_W               = LUM_W + RATIO_W;
    localparam int LANE_STAGES         = 3;
    localparam int IN_DATA_W           = 6 * CHANNEL_BITS;

    // Luminance weights scaled by 10000, and the 0.05 offset in the same scale.
    localparam int unsigned W_RED   = 2126;
    localparam int unsigned W_GREEN = 7152;
    localparam int unsigned W_BLUE  = 722;
    localparam logic [LUM_W-1:0] LUM_OFFSET = LUM_W'(500) << Q_BITS;

    // Constants for building the linearization table.
    localparam longint unsigned CODE_MAX   = longint'(LEVELS - 1);
    localparam longint unsigned Q_ONE      = 64'd1 << Q_BITS;
    localparam longint unsigned DARK_DIV   = 1292 * CODE_MAX;
    localparam longint unsigned BRIGHT_DIV = 1055 * CODE_MAX;

    typedef logic [LIN_W-1:0] lin_rom_t [LEVELS];

    typedef struct packed {
        logic [LANE_STAGES-1:0] stage;
    } lane_load_t;

    // Q30 product, floored.
    function automatic longint unsigned q_mul(input longint unsigned a,
                                              input longint unsigned b);
        return (a * b) >> Q_BITS;
    endfunction

    // Fifth power by four floored Q30 products.
    function automatic longint unsigned q_pow5(input longint unsigned y);
        longint unsigned r;
        r = y;
        for (int k = 0; k < 4; k++)
        begin
            r = q_mul(r, y);
        end
        return r;
    endfunction

    // Linear value of one channel code in Q30.
    function automatic logic [LIN_W-1:0] lin_value(input longint unsigned i);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (100000 * i <= 3928 * CODE_MAX)
        begin
            return LIN_W'(((100 * i) << Q_BITS) / DARK_DIV);
        end
        t  = ((1000 * i + 55 * CODE_MAX) << Q_BITS) / BRIGHT_DIV;
        t2 = q_mul(t, t);
        // Binary search for the fifth root of t squared.
        lo = 0;
        hi = Q_ONE;
        for (int n = 0; n < 40; n++)
        begin
            if (lo < hi)
            begin
                mid = lo + ((hi - lo + 1) >> 1);
                if (q_pow5(mid) <= t2)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
        end
        return LIN_W'(q_mul(t2, lo));
    endfunction

    function automatic lin_rom_t build_lin_rom();
        lin_rom_t rom;
        for (int i = 0; i < LEVELS; i++)
        begin
            rom[i] = lin_value(longint'(i));
        end
        return rom;
    endfunction

    // Linearization table, computed at elaboration.
    localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

// File: hdl/srgb_contrast_ratio_top.sv
// Contrast ratio of two sRGB colors with 8-bit channels.
//
// Input channel (s_*): one word carries both colors, six 8-bit channel
// codes. Output channel (m_*): one word per input word, the ratio of
// (brighter + 0.05) to (darker + 0.05) as an unsigned 16-bit value with
// 11 fraction bits, from 1.0 (2048) to 21.0 (43008), rounded down.
//
// Each luminance lane has the stages table lookup, weighting and sum; a
// merge stage then orders the luminances, and the pipelined divider
// follows with one quotient bit per stage. A new word is accepted every
// cycle unless a stall on m_tready has filled the pipeline.
//
// Each pipeline stage holds its word while its successor is full and
// stalled, so a stall on m_tready backs up only as far as needed; while
// any stage is empty, s_tready stays high. Reset empties the pipeline.
// The linearization table is a constant, so no warm-up follows reset.
module srgb_contrast_ratio_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_red, first_green, first_blue, second_red, second_green,
    // second_blue (8 bits each, from the lowest bit up)
    input  logic [srgb_cr_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // ratio (16 bits)
    output logic [srgb_cr_pkg::RATIO_W-1:0]     m_tdata
);
    import srgb_cr_pkg::*;

    localparam int CB = CHANNEL_BITS;

    logic             lane_valid_reg [LANE_STAGES];
    logic             stage_ready    [LANE_STAGES];
    lane_load_t       lane_load;
    logic [LUM_W-1:0] lum_a;
    logic [LUM_W-1:0] lum_b;
    logic             merge_in_ready;
    logic             merge_valid;
    logic             div_in_ready;
    logic [LUM_W-1:0] num;
    logic [LUM_W-1:0] den;

    // Lane stage control, shared by both lanes.
    always_comb
    begin
        stage_ready[LANE_STAGES-1] = !lane_valid_reg[LANE_STAGES-1] || merge_in_ready;
        for (int k = LANE_STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !lane_valid_reg[k] || stage_ready[k+1];
        end
        for (int k = 0; k < LANE_STAGES; k++)
        begin
            lane_load.stage[k] = stage_ready[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LANE_STAGES; k++)
            begin
                lane_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (stage_ready[0])
            begin
                lane_valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < LANE_STAGES; k++)
            begin
                if (stage_ready[k])
                begin
                    lane_valid_reg[k] <= lane_valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = stage_ready[0];

    // One luminance lane per color.
    srgb_cr_lane u_lane_a (
        .clk   (clk),
        .load  (lane_load),
        .red   (s_tdata[0*CB +: CB]),
        .green (s_tdata[1*CB +: CB]),
        .blue  (s_tdata[2*CB +: CB]),
        .lum   (lum_a)
    );

    srgb_cr_lane u_lane_b (
        .clk   (clk),
        .load  (lane_load),
        .red   (s_tdata[3*CB +: CB]),
        .green (s_tdata[4*CB +: CB]),
        .blue  (s_tdata[5*CB +: CB]),
        .lum   (lum_b)
    );

    // Merge the lanes: brighter over darker, each with the offset.
    srgb_cr_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lane_valid_reg[LANE_STAGES-1]),
        .in_ready  (merge_in_ready),
        .lum_a     (lum_a),
        .lum_b     (lum_b),
        .out_valid (merge_valid),
        .out_ready (div_in_ready),
        .num       (num),
        .den       (den)
    );

    // Pipelined long division; its last stage is the output register.
    srgb_cr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (merge_valid),
        .in_ready  (div_in_ready),
        .num       (num),
        .den       (den),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ratio     (m_tdata)
    );

endmodule

// File: hdl/srgb_cr_lane.sv
module srgb_cr_lane (
    input  logic                                 clk,
    input  srgb_cr_pkg::lane_load_t              load,
    input  logic [srgb_cr_pkg::CHANNEL_BITS-1:0] red,
    input  logic [srgb_cr_pkg::CHANNEL_BITS-1:0] green,
    input  logic [srgb_cr_pkg::CHANNEL_BITS-1:0] blue,
    output logic [srgb_cr_pkg::LUM_W-1:0]        lum
);
    import srgb_cr_pkg::*;

    logic [LIN_W-1:0] lin_r_reg;
    logic [LIN_W-1:0] lin_g_reg;
    logic [LIN_W-1:0] lin_b_reg;
    logic [LUM_W-1:0] prod_r_reg;
    logic [LUM_W-1:0] prod_g_reg;
    logic [LUM_W-1:0] prod_b_reg;
    logic [LUM_W-1:0] lum_reg;

    // Stage 0: table lookup of the three channels.
    always_ff @(posedge clk)
    begin
        if (load.stage[0])
        begin
            lin_r_reg <= LIN_ROM[red];
            lin_g_reg <= LIN_ROM[green];
            lin_b_reg <= LIN_ROM[blue];
        end
    end

    // Stage 1: weight each linear channel.
    always_ff @(posedge clk)
    begin
        if (load.stage[1])
        begin
            prod_r_reg <= LUM_W'(W_RED) * LUM_W'(lin_r_reg);
            prod_g_reg <= LUM_W'(W_GREEN) * LUM_W'(lin_g_reg);
            prod_b_reg <= LUM_W'(W_BLUE) * LUM_W'(lin_b_reg);
        end
    end

    // Stage 2: sum to the scaled relative luminance.
    always_ff @(posedge clk)
    begin
        if (load.stage[2])
        begin
            lum_reg <= prod_r_reg + prod_g_reg + prod_b_reg;
        end
    end

    assign lum = lum_reg;

endmodule

// File: hdl/srgb_cr_merge.sv
module srgb_cr_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [srgb_cr_pkg::LUM_W-1:0] lum_a,
    input  logic [srgb_cr_pkg::LUM_W-1:0] lum_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [srgb_cr_pkg::LUM_W-1:0] num,
    output logic [srgb_cr_pkg::LUM_W-1:0] den
);
    import srgb_cr_pkg::*;

    logic             valid_reg;
    logic [LUM_W-1:0] num_reg;
    logic [LUM_W-1:0] den_reg;
    logic             a_brighter;

    assign in_ready   = !valid_reg || out_ready;
    assign a_brighter = lum_a > lum_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Order the two luminances and add the offset to both.
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            num_reg <= (a_brighter ? lum_a : lum_b) + LUM_OFFSET;
            den_reg <= (a_brighter ? lum_b : lum_a) + LUM_OFFSET;
        end
    end

    assign out_valid = valid_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

// File: hdl/srgb_cr_div.sv
module srgb_cr_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [srgb_cr_pkg::LUM_W-1:0]   num,
    input  logic [srgb_cr_pkg::LUM_W-1:0]   den,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [srgb_cr_pkg::RATIO_W-1:0] ratio
);
    import srgb_cr_pkg::*;

    logic               valid_reg [RATIO_W];
    logic [DIV_W-1:0]   rem_reg   [RATIO_W];
    logic [LUM_W-1:0]   den_reg   [RATIO_W];
    logic [RATIO_W-1:0] q_reg     [RATIO_W];

    logic               stage_ready [RATIO_W];
    logic [DIV_W-1:0]   rem_in      [RATIO_W];
    logic [LUM_W-1:0]   den_in      [RATIO_W];
    logic [RATIO_W-1:0] q_in        [RATIO_W];
    logic [DIV_W-1:0]   rem_next    [RATIO_W];
    logic [RATIO_W-1:0] q_next      [RATIO_W];
    logic [DIV_W-1:0]   shifted     [RATIO_W];

    // A stage may load when it is empty or its successor moves on.
    always_comb
    begin
        stage_ready[RATIO_W-1] = !valid_reg[RATIO_W-1] || out_ready;
        for (int k = RATIO_W - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    // One quotient bit per stage, most significant first.
    always_comb
    begin
        rem_in[0] = DIV_W'(num) << RATIO_FRACTION_BITS;
        den_in[0] = den;
        q_in[0]   = '0;
        for (int k = 1; k < RATIO_W; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            den_in[k] = den_reg[k-1];
            q_in[k]   = q_reg[k-1];
        end
        for (int k = 0; k < RATIO_W; k++)
        begin
            shifted[k] = DIV_W'(den_in[k]) << (RATIO_W - 1 - k);
            if (rem_in[k] >= shifted[k])
            begin
                rem_next[k] = rem_in[k] - shifted[k];
                q_next[k]   = q_in[k] | (RATIO_W'(1) << (RATIO_W - 1 - k));
            end
            else
            begin
                rem_next[k] = rem_in[k];
                q_next[k]   = q_in[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RATIO_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < RATIO_W; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RATIO_W; k++)
        begin
            if (stage_ready[k])
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[RATIO_W-1];
    assign ratio     = q_reg[RATIO_W-1];

endmodule
